// ===== sv/attitude_angle_pid_controller_core_macros.svh =====
// Assertion macros shared by the attitude controller RTL.
`ifndef ATTITUDE_ANGLE_PID_CONTROLLER_CORE_MACROS_SVH
`define ATTITUDE_ANGLE_PID_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define AAPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("attitude controller check failed");

// Next-cycle implication.
`define AAPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("attitude controller check failed");

`endif

// ===== sv/aapc_pkg.sv =====
// Package: types, constants and codes of the attitude PID controller.
package aapc_pkg;

  localparam int unsigned PulseW  = 12;
  localparam int unsigned DataW   = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned OffsW   = PulseW + 1;  // stick offset, signed
  localparam int unsigned ErrW    = 30;          // angle/rate error, Q.16
  localparam int unsigned IntegW  = 25;          // integrator, Q9.16
  localparam int unsigned ProdW   = ErrW + GainW + 1;
  localparam int unsigned AccW    = ProdW + 1;   // Q.28 sum

  localparam int unsigned StickAngleQ16 = 2621;   // 0.04 deg per us
  localparam int unsigned YawRateQ16    = 52429;  // 0.8 deg/s per us
  localparam int unsigned DtQ16         = 328;    // 0.005 s
  localparam int unsigned IntegLimit    = 9830400; // 150.0 in Q9.16
  localparam int unsigned FracShift     = 16;
  localparam int unsigned OutShift      = 24;
  localparam int unsigned RateShift     = 12;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgAngleP  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAngleI  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAngleD  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgYawP    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgArmThr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStickCtr = 3'd5;

  localparam logic [GainW-1:0]  AnglePReset  = 16'd10240;
  localparam logic [GainW-1:0]  AngleIReset  = 16'd205;
  localparam logic [GainW-1:0]  AngleDReset  = 16'd614;
  localparam logic [GainW-1:0]  YawPReset    = 16'd2458;
  localparam logic [PulseW-1:0] ArmThrReset  = 12'd1050;
  localparam logic [PulseW-1:0] StickCtrReset = 12'd1500;

  typedef struct packed {
    logic [PulseW-1:0]       throttle_pulse;
    logic [PulseW-1:0]       roll_stick;
    logic [PulseW-1:0]       pitch_stick;
    logic [PulseW-1:0]       yaw_stick;
    logic signed [DataW-1:0] angle_x;
    logic signed [DataW-1:0] angle_y;
    logic signed [DataW-1:0] rate_x;
    logic signed [DataW-1:0] rate_y;
    logic signed [DataW-1:0] rate_z;
  } aapc_in_t;

  typedef struct packed {
    logic                    motors_stopped;
    logic [PulseW-1:0]       throttle_out;
    logic signed [DataW-1:0] roll_adjust;
    logic signed [DataW-1:0] pitch_adjust;
    logic signed [DataW-1:0] yaw_adjust;
  } aapc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD
  } state_e;

  // Steps of one lane, one per cycle
  typedef enum logic [2:0] {
    PH_OFFSET,
    PH_ERROR,
    PH_STEP,
    PH_INTEG,
    PH_PTERM,
    PH_DTERM,
    PH_ITERM,
    PH_ROUND
  } phase_e;

  typedef struct packed {
    logic   run;
    logic   clear;
    phase_e phase;
  } lane_ctrl_t;

endpackage

// ===== sv/aapc_lane.sv =====
// One controller lane: error, integrator and P+I+D sum on a shared multiplier.
module aapc_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  aapc_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [aapc_pkg::DataW-1:0]  meas_i,
  input  logic signed [aapc_pkg::OffsW-1:0]  offs_i,
  input  logic        [aapc_pkg::GainW-1:0]  coef_i,
  input  logic signed [aapc_pkg::DataW-1:0]  rate_i,
  input  logic        [aapc_pkg::GainW-1:0]  kp_i,
  input  logic        [aapc_pkg::GainW-1:0]  ki_i,
  input  logic        [aapc_pkg::GainW-1:0]  kd_i,
  output logic signed [aapc_pkg::DataW-1:0]  adj_o
);
  import aapc_pkg::*;

  localparam int unsigned StepW   = ProdW - FracShift;
  localparam int unsigned SumW    = IntegW + 1;
  localparam int unsigned RndW    = AccW - OutShift;
  localparam logic signed [SumW-1:0]  SumMax  = SumW'(IntegLimit);
  localparam logic signed [SumW-1:0]  SumMin  = -SumMax;
  localparam logic signed [ProdW-1:0] StepHalf = ProdW'(1) <<< (FracShift - 1);
  localparam logic signed [AccW-1:0]  OutHalf  = AccW'(1) <<< (OutShift - 1);
  localparam logic signed [RndW-1:0]  OutMax   = RndW'((1 << (DataW - 1)) - 1);
  localparam logic signed [RndW-1:0]  OutMin   = -OutMax - RndW'(1);

  logic signed [ErrW-1:0]   err_q;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [ProdW-1:0]  prod_q, mul_p, step_rnd;
  logic signed [AccW-1:0]   acc_q, acc_rnd;
  logic signed [DataW-1:0]  adj_q, adj_d;
  logic signed [ErrW-1:0]   mul_a;
  logic        [GainW-1:0]  mul_b;
  logic signed [StepW-1:0]  step;
  logic signed [SumW-1:0]   integ_sum;
  logic signed [RndW-1:0]   out_rnd;

  // Operand select for the lane multiplier
  always_comb begin
    mul_a = err_q;
    mul_b = kp_i;
    case (ctrl_i.phase)
      PH_OFFSET: begin
        mul_a = ErrW'(offs_i);
        mul_b = coef_i;
      end
      PH_STEP: begin
        mul_a = err_q;
        mul_b = GainW'(DtQ16);
      end
      PH_INTEG: begin
        mul_a = err_q;
        mul_b = kp_i;
      end
      PH_PTERM: begin
        mul_a = ErrW'(rate_i);
        mul_b = kd_i;
      end
      PH_DTERM: begin
        mul_a = ErrW'(integ_q);
        mul_b = ki_i;
      end
      default: begin
        mul_a = err_q;
        mul_b = kp_i;
      end
    endcase
  end

  assign mul_p = ProdW'(mul_a) * ProdW'(signed'({1'b0, mul_b}));

  // Integrator update: round error*dt to Q.16 and saturate
  always_comb begin
    step_rnd  = prod_q + StepHalf;
    step      = step_rnd[ProdW-1:FracShift];
    integ_sum = SumW'(integ_q) + SumW'(step);
    if (integ_sum > SumMax) begin
      integ_d = IntegW'(SumMax);
    end else if (integ_sum < SumMin) begin
      integ_d = IntegW'(SumMin);
    end else begin
      integ_d = IntegW'(integ_sum);
    end
  end

  // Output rounding from Q.28 to Q.4, saturated
  always_comb begin
    acc_rnd = acc_q + OutHalf;
    out_rnd = acc_rnd[AccW-1:OutShift];
    if (out_rnd > OutMax) begin
      adj_d = DataW'(OutMax);
    end else if (out_rnd < OutMin) begin
      adj_d = DataW'(OutMin);
    end else begin
      adj_d = DataW'(out_rnd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.clear) begin
      integ_q <= '0;
    end else if (ctrl_i.run && ctrl_i.phase == PH_INTEG) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.run) begin
      case (ctrl_i.phase)
        PH_OFFSET: prod_q <= mul_p;
        PH_ERROR:  err_q  <= (ErrW'(meas_i) <<< RateShift) + ErrW'(prod_q);
        PH_STEP:   prod_q <= mul_p;
        PH_INTEG:  prod_q <= mul_p;
        PH_PTERM: begin
          acc_q  <= AccW'(prod_q);
          prod_q <= mul_p;
        end
        PH_DTERM: begin
          acc_q  <= acc_q + (AccW'(prod_q) <<< RateShift);
          prod_q <= mul_p;
        end
        PH_ITERM:  acc_q <= acc_q + AccW'(prod_q);
        PH_ROUND:  adj_q <= adj_d;
        default:   adj_q <= adj_q;
      endcase
    end
  end

  assign adj_o = adj_q;

endmodule

// ===== sv/aapc_merge.sv =====
// Merge stage: combines lane results into the registered output transaction.
module aapc_merge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  aapc_pkg::aapc_out_t  lanes_i,
  output logic                 can_load_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output aapc_pkg::aapc_out_t  out_data_o
);
  import aapc_pkg::*;

  logic      valid_q;
  aapc_out_t data_q, data_d;

  assign can_load_o = !valid_q || out_ready_i;

  // Disarmed ticks report zero adjustments
  always_comb begin
    data_d = lanes_i;
    if (lanes_i.motors_stopped) begin
      data_d.roll_adjust  = '0;
      data_d.pitch_adjust = '0;
      data_d.yaw_adjust   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && can_load_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/attitude_angle_pid_controller_core.sv =====
// Top level of the angle-mode PID attitude controller.
//
// One input transaction is one control tick; it yields exactly one output
// transaction. An armed tick reaches the result register through eight
// steps on each lane's single 30x17 multiplier (stick offset, error, dt
// step, integrator and P product, D product, I product, I accumulate,
// rounding), then the load of the output register. The input is ready
// again in the cycle after that load. A disarmed tick (throttle below the
// arm threshold) skips the lanes and goes straight to the load. If the
// output register still holds an unread result, the load waits, and the
// input with it, until the consumer takes that result. The next input is
// accepted once the previous result sits in the output register, even
// while that result waits for the consumer. Three identical lanes run
// side by side: roll, pitch, and yaw. The yaw lane gets zero I and D
// gains, so only its P term reaches the output. Configuration writes are
// always accepted and take effect at once; write them only while the
// block is idle. Indexes past the last register are ignored.
module attitude_angle_pid_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  aapc_pkg::aapc_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output aapc_pkg::aapc_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [aapc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [aapc_pkg::GainW-1:0]      cfg_data_i
);
  import aapc_pkg::*;

  `include "attitude_angle_pid_controller_core_macros.svh"

  // Configuration registers
  logic [GainW-1:0]  angle_p_q, angle_i_q, angle_d_q, yaw_p_q;
  logic [PulseW-1:0] arm_thr_q, stick_ctr_q;

  // Control
  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic       stopped_q;
  aapc_in_t   in_q;
  lane_ctrl_t lane_ctrl;
  logic       in_acc, disarmed, can_load, load;

  // Lane operands
  logic signed [OffsW-1:0] roll_offs, pitch_offs, yaw_offs;
  logic signed [DataW-1:0] roll_adj, pitch_adj, yaw_adj;
  aapc_out_t               lanes;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_p_q   <= AnglePReset;
      angle_i_q   <= AngleIReset;
      angle_d_q   <= AngleDReset;
      yaw_p_q     <= YawPReset;
      arm_thr_q   <= ArmThrReset;
      stick_ctr_q <= StickCtrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAngleP:   angle_p_q   <= cfg_data_i;
        CfgAngleI:   angle_i_q   <= cfg_data_i;
        CfgAngleD:   angle_d_q   <= cfg_data_i;
        CfgYawP:     yaw_p_q     <= cfg_data_i;
        CfgArmThr:   arm_thr_q   <= cfg_data_i[PulseW-1:0];
        CfgStickCtr: stick_ctr_q <= cfg_data_i[PulseW-1:0];
        default:     ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign disarmed   = in_data_i.throttle_pulse < arm_thr_q;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_OFFSET;
      stopped_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (in_acc) begin
        stopped_q <= disarmed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        phase_d = PH_OFFSET;
        if (in_acc) begin
          state_d = disarmed ? ST_LOAD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (phase_q == PH_ROUND) begin
          state_d = ST_LOAD;
          phase_d = PH_OFFSET;
        end else begin
          phase_d = phase_e'(3'(phase_q) + 3'd1);
        end
      end
      ST_LOAD: begin
        load = 1'b1;
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign lane_ctrl.run   = (state_q == ST_RUN);
  assign lane_ctrl.clear = in_acc && disarmed;
  assign lane_ctrl.phase = phase_q;

  // Setpoint offsets; the sign folds in the direction of each axis
  assign roll_offs  = signed'(OffsW'(in_q.roll_stick)) - signed'(OffsW'(stick_ctr_q));
  assign pitch_offs = signed'(OffsW'(stick_ctr_q)) - signed'(OffsW'(in_q.pitch_stick));
  assign yaw_offs   = signed'(OffsW'(stick_ctr_q)) - signed'(OffsW'(in_q.yaw_stick));

  aapc_lane u_lane_roll (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lane_ctrl),
    .meas_i (in_q.angle_y),
    .offs_i (roll_offs),
    .coef_i (GainW'(StickAngleQ16)),
    .rate_i (in_q.rate_y),
    .kp_i   (angle_p_q),
    .ki_i   (angle_i_q),
    .kd_i   (angle_d_q),
    .adj_o  (roll_adj)
  );

  aapc_lane u_lane_pitch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lane_ctrl),
    .meas_i (in_q.angle_x),
    .offs_i (pitch_offs),
    .coef_i (GainW'(StickAngleQ16)),
    .rate_i (in_q.rate_x),
    .kp_i   (angle_p_q),
    .ki_i   (angle_i_q),
    .kd_i   (angle_d_q),
    .adj_o  (pitch_adj)
  );

  // Yaw is rate-only: no integral or damping contribution
  aapc_lane u_lane_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (lane_ctrl),
    .meas_i (in_q.rate_z),
    .offs_i (yaw_offs),
    .coef_i (GainW'(YawRateQ16)),
    .rate_i ('0),
    .kp_i   (yaw_p_q),
    .ki_i   ('0),
    .kd_i   ('0),
    .adj_o  (yaw_adj)
  );

  assign lanes.motors_stopped = stopped_q;
  assign lanes.throttle_out   = in_q.throttle_pulse;
  assign lanes.roll_adjust    = roll_adj;
  assign lanes.pitch_adjust   = pitch_adj;
  assign lanes.yaw_adjust     = yaw_adj;

  aapc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .lanes_i     (lanes),
    .can_load_o  (can_load),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // Checks
  `AAPC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `AAPC_ASSERT_SAME(a_stopped_zero, out_valid_o && out_data_o.motors_stopped, out_data_o.roll_adjust == '0 && out_data_o.pitch_adjust == '0 && out_data_o.yaw_adjust == '0)
  `AAPC_ASSERT_NEXT(a_load_shows, state_q == ST_LOAD && can_load, out_valid_o && in_ready_o)

endmodule

// ===== sim/attitude_angle_pid_controller_core_test.sv =====
// Self-checking testbench of the attitude PID controller: directed table, random flight runs.
module attitude_angle_pid_controller_core_test;
  import aapc_pkg::*;

  // Clock, reset and handshake signals. Inputs are driven on the falling edge,
  // outputs are sampled on the rising edge, so nothing races within a step.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  aapc_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  aapc_out_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [GainW-1:0]     cfg_data_i  = '0;

  // Indexes past the last register: writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  localparam logic signed [DataW-1:0] SatHi = 16'sh7FFF;
  localparam logic signed [DataW-1:0] SatLo = 16'sh8000;

  localparam longint StickQ16   = StickAngleQ16;
  localparam longint YawQ16     = YawRateQ16;
  localparam longint StepQ16    = DtQ16;
  localparam longint AccLimit   = IntegLimit;
  localparam int     CycleLimit = 400000;
  localparam int     TailCycles = 16;   // a bit more than the armed latency
  localparam int     MaxReports = 10;

  attitude_angle_pid_controller_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Controller model: register copies, both integrators, one tick at a time.
  // ---------------------------------------------------------------------------
  longint kp         = longint'(AnglePReset);
  longint ki         = longint'(AngleIReset);
  longint kd         = longint'(AngleDReset);
  longint kyaw       = longint'(YawPReset);
  longint arm_level  = longint'(ArmThrReset);
  longint stick_zero = longint'(StickCtrReset);
  longint roll_acc   = 0;   // Q9.16 degree-seconds
  longint pitch_acc  = 0;

  function automatic longint clip(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // round to nearest, ties toward +inf; >>> on a signed longint floors
  function automatic longint round_down(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic signed [DataW-1:0] to_q4(longint sum_q28);
    return DataW'(clip(round_down(sum_q28, OutShift), -32768, 32767));
  endfunction

  function automatic longint integrate(longint acc, longint err);
    return clip(acc + round_down(err * StepQ16, FracShift), -AccLimit, AccLimit);
  endfunction

  function automatic logic signed [DataW-1:0] axis_out(longint err, longint acc,
                                                       longint rate);
    return to_q4(err * kp + acc * ki + rate * kd * 4096);
  endfunction

  function automatic void load_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] v);
    case (idx)
      CfgAngleP:   kp = longint'(v);
      CfgAngleI:   ki = longint'(v);
      CfgAngleD:   kd = longint'(v);
      CfgYawP:     kyaw = longint'(v);
      CfgArmThr:   arm_level = longint'(v[PulseW-1:0]);
      CfgStickCtr: stick_zero = longint'(v[PulseW-1:0]);
      default: ;
    endcase
  endfunction

  function automatic aapc_out_t control_tick(aapc_in_t t);
    aapc_out_t r;
    longint    dr, dp, dy, roll_err, pitch_err, yaw_err;
    r = '0;
    r.throttle_out = t.throttle_pulse;
    // disarmed: stop motors, zero outputs, drop both integrators
    if (longint'(t.throttle_pulse) < arm_level) begin
      roll_acc = 0;
      pitch_acc = 0;
      r.motors_stopped = 1'b1;
      return r;
    end
    dr = longint'(t.roll_stick) - stick_zero;
    dp = longint'(t.pitch_stick) - stick_zero;
    dy = longint'(t.yaw_stick) - stick_zero;
    // roll setpoint is inverted, hence the plus
    roll_err  = longint'(t.angle_y) * 4096 + dr * StickQ16;
    pitch_err = longint'(t.angle_x) * 4096 - dp * StickQ16;
    yaw_err   = longint'(t.rate_z) * 4096 - dy * YawQ16;
    roll_acc  = integrate(roll_acc, roll_err);
    pitch_acc = integrate(pitch_acc, pitch_err);
    r.roll_adjust  = axis_out(roll_err, roll_acc, longint'(t.rate_y));
    r.pitch_adjust = axis_out(pitch_err, pitch_acc, longint'(t.rate_x));
    r.yaw_adjust   = to_q4(yaw_err * kyaw);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed = 1 carry an obvious expected output
  // (disarmed ticks, all-zero error, hard saturation); the rest go through
  // the model. Fields: throttle, roll, pitch, yaw, angle_x, angle_y,
  // rate_x, rate_y, rate_z.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    aapc_in_t  tick;
    logic      typed;
    aapc_out_t want;
  } dir_row_t;

  localparam int DirRows = 19;

  dir_row_t dir_table [DirRows] = '{
    // everything zero: disarmed
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b1, '{1'b1, 12'd0, 16'sh0, 16'sh0, 16'sh0}},
    // one below the arm threshold, wild fields ignored
    '{'{12'd1049, 12'd4095, 12'd4095, 12'd4095, SatHi, SatHi, SatLo, SatLo, SatLo},
      1'b1, '{1'b1, 12'd1049, 16'sh0, 16'sh0, 16'sh0}},
    // exactly at threshold, level and centered: armed, zero error
    '{'{12'd1050, 12'd1500, 12'd1500, 12'd1500, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b1, '{1'b0, 12'd1050, 16'sh0, 16'sh0, 16'sh0}},
    // full throttle, extreme angles and yaw: every adjustment saturates
    '{'{12'd4095, 12'd1500, 12'd1500, 12'd4095, SatLo, SatHi, 16'sh0, 16'sh0, SatLo},
      1'b1, '{1'b0, 12'd4095, SatHi, SatLo, SatLo}},
    '{'{12'd4095, 12'd1500, 12'd1500, 12'd0, SatHi, SatLo, 16'sh0, 16'sh0, SatHi},
      1'b0, '0},
    // sticks outside the usual range
    '{'{12'd1500, 12'd0, 12'd0, 12'd0, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd2000, 12'd4095, 12'd4095, 12'd4095, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    // gyro damping only
    '{'{12'd3000, 12'd1500, 12'd1500, 12'd1500, 16'sh0, 16'sh0, SatHi, SatLo, 16'sh0},
      1'b0, '0},
    '{'{12'd3000, 12'd1500, 12'd1500, 12'd1500, 16'sh0, 16'sh0, SatLo, SatHi, 16'sh0},
      1'b0, '0},
    // steady 200 degree error, integrators build up
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd1800, 12'd1500, 12'd1500, 12'd1500, 16'sh0C80, 16'shF380, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    // disarm mid-flight, throttle still passes through
    '{'{12'd1000, 12'd1234, 12'd2345, 12'd3456, 16'sh1234, 16'shEDCB, 16'sh0101, 16'sh7F00,
        16'sh8001}, 1'b1, '{1'b1, 12'd1000, 16'sh0, 16'sh0, 16'sh0}},
    // re-arm level: integrators must have been cleared
    '{'{12'd1050, 12'd1500, 12'd1500, 12'd1500, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b1, '{1'b0, 12'd1050, 16'sh0, 16'sh0, 16'sh0}},
    // smallest nonzero angle and stick offsets
    '{'{12'd4095, 12'd1500, 12'd1500, 12'd1500, 16'sh0, 16'shFFFF, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0},
    '{'{12'd2500, 12'd1501, 12'd1499, 12'd1501, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh0},
      1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Scoreboard state
  // ---------------------------------------------------------------------------
  aapc_out_t pending_outputs [$];   // expected results, oldest first
  aapc_out_t oldest;
  int        fail_count  = 0;
  int        n_sent      = 0;
  int        n_results   = 0;
  int        n_stopped   = 0;
  int        n_saturated = 0;
  int        n_settings  = 1;       // reset values count as the first
  int        cycles      = 0;

  // Idle control, written by the main sequence only.
  logic      steady    = 1'b0;      // 1: neither side idles
  int        hold_len  = 0;
  int        hold_asks = 0;

  // Output side: random back-pressure plus long hold-offs on request.
  int        hold_seen = 0;
  int        hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = steady || ($urandom_range(0, 99) >= 12);
    end
  end

  // Output monitor: every accepted transaction against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (out_data_o.motors_stopped) n_stopped++;
      if (out_data_o.roll_adjust inside {SatHi, SatLo} ||
          out_data_o.pitch_adjust inside {SatHi, SatLo} ||
          out_data_o.yaw_adjust inside {SatHi, SatLo}) n_saturated++;
      if (pending_outputs.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("ERROR: result with nothing expected: stop=%0d thr=%0d r=%0d p=%0d y=%0d",
                   out_data_o.motors_stopped, out_data_o.throttle_out,
                   out_data_o.roll_adjust, out_data_o.pitch_adjust, out_data_o.yaw_adjust);
      end else begin
        oldest = pending_outputs.pop_front();
        if (out_data_o.motors_stopped !== oldest.motors_stopped ||
            out_data_o.throttle_out   !== oldest.throttle_out   ||
            out_data_o.roll_adjust    !== oldest.roll_adjust    ||
            out_data_o.pitch_adjust   !== oldest.pitch_adjust   ||
            out_data_o.yaw_adjust     !== oldest.yaw_adjust) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("ERROR: result %0d mismatch", n_results);
            $display("  expected stop=%0d thr=%0d r=%0d p=%0d y=%0d",
                     oldest.motors_stopped, oldest.throttle_out,
                     oldest.roll_adjust, oldest.pitch_adjust, oldest.yaw_adjust);
            $display("  actual   stop=%0d thr=%0d r=%0d p=%0d y=%0d",
                     out_data_o.motors_stopped, out_data_o.throttle_out,
                     out_data_o.roll_adjust, out_data_o.pitch_adjust, out_data_o.yaw_adjust);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycles, pending_outputs.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge; returns at the falling edge after
  // the transaction, with valid still up so back-to-back ticks need no gap.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input aapc_in_t t, input logic typed, input aapc_out_t want);
    aapc_out_t guess;
    while (!steady && $urandom_range(0, 99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = t;
    do @(posedge clk_i); while (!in_ready_o);
    guess = control_tick(t);   // always run: keeps the integrators in step
    pending_outputs.push_back(typed ? want : guess);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    load_reg(idx, v);
    @(negedge clk_i);
  endtask

  // One full register setting; the spare indexes get junk that must be dropped.
  task automatic program_regs(input logic [GainW-1:0] p, input logic [GainW-1:0] i,
                              input logic [GainW-1:0] d, input logic [GainW-1:0] y,
                              input logic [GainW-1:0] thr, input logic [GainW-1:0] ctr);
    cfg_write(CfgAngleP, p);
    cfg_write(CfgSpareA, 16'($urandom));
    cfg_write(CfgAngleI, i);
    cfg_write(CfgAngleD, d);
    cfg_write(CfgYawP, y);
    cfg_write(CfgArmThr, thr);
    cfg_write(CfgSpareB, 16'($urandom));
    cfg_write(CfgStickCtr, ctr);
    cfg_valid_i = 1'b0;
    n_settings++;
  endtask

  // Random flight: runs of ticks around a held attitude so the integrators
  // wind up, mixed with disarmed stretches and fully random noise.
  task automatic run_phase(input int n_ticks, input logic no_idle, input int hold);
    aapc_in_t          t;
    int                sent, seg, kind;
    logic              wide;
    logic [DataW-1:0]  bx, by, brx, bry, brz;
    steady = no_idle;
    if (hold > 0) begin
      hold_len = hold;
      hold_asks++;
    end
    sent = 0;
    while (sent < n_ticks) begin
      seg  = $urandom_range(1, 40);
      kind = $urandom_range(0, 99);
      wide = ($urandom_range(0, 99) < 35);
      bx   = wide ? 16'($urandom) : 16'($urandom_range(0, 2047)) - 16'd1024;
      by   = wide ? 16'($urandom) : 16'($urandom_range(0, 2047)) - 16'd1024;
      brx  = wide ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'd2048;
      bry  = wide ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'd2048;
      brz  = wide ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'd2048;
      for (int k = 0; k < seg && sent < n_ticks; k++) begin
        t.throttle_pulse = 12'($urandom);
        t.roll_stick     = 12'($urandom);
        t.pitch_stick    = 12'($urandom);
        t.yaw_stick      = 12'($urandom);
        t.angle_x        = 16'($urandom);
        t.angle_y        = 16'($urandom);
        t.rate_x         = 16'($urandom);
        t.rate_y         = 16'($urandom);
        t.rate_z         = 16'($urandom);
        if (kind < 15) begin
          // pure noise
        end else if (kind < 30 && arm_level > 0) begin
          t.throttle_pulse = 12'($urandom_range(0, int'(arm_level) - 1));
        end else begin
          t.throttle_pulse = 12'($urandom_range(4095, int'(arm_level)));
          t.roll_stick     = 12'(stick_zero + longint'($urandom_range(0, 800)) - 400);
          t.pitch_stick    = 12'(stick_zero + longint'($urandom_range(0, 800)) - 400);
          t.yaw_stick      = 12'(stick_zero + longint'($urandom_range(0, 800)) - 400);
          t.angle_x        = bx + 16'($urandom_range(0, 255)) - 16'd128;
          t.angle_y        = by + 16'($urandom_range(0, 255)) - 16'd128;
          t.rate_x         = brx + 16'($urandom_range(0, 511)) - 16'd256;
          t.rate_y         = bry + 16'($urandom_range(0, 511)) - 16'd256;
          t.rate_z         = brz + 16'($urandom_range(0, 511)) - 16'd256;
        end
        send_tick(t, 1'b0, '0);
        sent++;
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows at reset values
    for (int r = 0; r < DirRows; r++)
      send_tick(dir_table[r].tick, dir_table[r].typed, dir_table[r].want);
    drain();

    // reset values, long output hold-off at the start fills the block
    run_phase(250, 1'b0, 300);

    // everything at its top: 12-bit registers see the upper bits masked,
    // so only full throttle arms
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(150, 1'b0, 0);

    // everything zero: never disarmed, pure rate damping gone, no idling
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(150, 1'b1, 0);

    // random settings, thresholds mostly in a sensible band
    for (int s = 0; s < 3; s++) begin
      program_regs(16'($urandom), 16'($urandom_range(0, 4095)), 16'($urandom),
                   16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(900, 1300)),
                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(1300, 1700)));
      run_phase(200, 1'b0, (s == 1) ? 200 : 0);
    end

    // back to the reset setting
    program_regs(AnglePReset, AngleIReset, AngleDReset, YawPReset,
                 16'(ArmThrReset), 16'(StickCtrReset));
    run_phase(200, 1'b0, 0);

    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d ticks (%0d from the table): %0d disarmed, %0d with a clipped adjust",
             n_results, DirRows, n_stopped, n_saturated);
    $display("Ran %0d register settings incl. extremes, spare indexes, long output hold-offs",
             n_settings);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
